// ----- src/psscan_pkg.sv -----
// ----------------------------------------------------------------------------
// psscan_pkg
// Shared types, widths and helpers for the prefix sum scan core.
// ----------------------------------------------------------------------------
package psscan_pkg;

  localparam int SAMPLE_W         = 32;
  localparam int SUM_W            = 40;
  localparam int IDX_W            = 6;
  localparam int LEN_W            = 7;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 7;
  localparam int OUT_TDATA_W      = 48;
  localparam int MAX_LINE_DEFAULT = 64;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = 7'd64;

  // Configuration register indexes; index 3 is outside the register list.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXCLUSIVE   = 2'd0,
    REG_REVERSE     = 2'd1,
    REG_LINE_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_EMIT = 2'd2
  } back_state_t;

  // One classified sample handed from the front end to the back end.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]    idx;
    logic                last;
    logic                rev;
    logic                excl;
  } cmd_t;

  function automatic logic [SUM_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v);
    sext_sample = {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

endpackage

// ----- src/prefix_sum_scan_core.sv -----
// ----------------------------------------------------------------------------
// prefix_sum_scan_core
// Inclusive or exclusive running sum along lines of Q16.16 samples, in
// forward or reverse order, producing Q24.16 sums.
// ----------------------------------------------------------------------------
//   Channel   Dir  Word contents (low bit first)
//   s_axis    in   tdata: sample_value[31:0]
//   m_axis    out  tdata: running_sum[39:0], element_index[45:40], zero pad;
//                  tlast: line_done
//   cfg       in   cfg_index: register (0 exclusive, 1 reverse, 2 length);
//                  cfg_data: value
//
// Forward mode: one sample per cycle while the output accepts words; its result
// word goes from the command queue into the output register. Reverse mode: the
// line is stored, then each result waits on a registered read of the line
// store, and no command is taken until the drain ends. Reset is synchronous
// and needs no clearing pass; the line store is always written within a line
// before it is read. Input and output stall independently through the
// two-entry command queue and the output register.
// ----------------------------------------------------------------------------
module prefix_sum_scan_core #(
  parameter int MAX_LINE = psscan_pkg::MAX_LINE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [psscan_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // sample_value
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [psscan_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // running_sum, element_index
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psscan_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psscan_pkg::CFG_DATA_W-1:0]   cfg_data
);

  psscan_pkg::cmd_t push_cmd;
  psscan_pkg::cmd_t head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;

  psscan_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  psscan_queue #(
    .DEPTH (psscan_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  psscan_back #(
    .MAX_LINE (MAX_LINE)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- src/psscan_ram.sv -----
// ----------------------------------------------------------------------------
// psscan_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module psscan_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/psscan_front.sv -----
// ----------------------------------------------------------------------------
// psscan_front
// Holds the configuration, tracks the position in the line and classifies
// each accepted sample into a command for the back end.
// ----------------------------------------------------------------------------
module psscan_front #(
  parameter int MAX_LINE = psscan_pkg::MAX_LINE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [psscan_pkg::SAMPLE_W-1:0]     s_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psscan_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psscan_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                q_full,
  output logic                                q_push,
  output psscan_pkg::cmd_t                    q_cmd
);

  localparam logic [psscan_pkg::LEN_W-1:0] MAX_LEN = psscan_pkg::LEN_W'(MAX_LINE);

  logic                           exclusive_mode;
  logic                           reverse_mode;
  logic [psscan_pkg::LEN_W-1:0]   line_length;
  logic [psscan_pkg::IDX_W-1:0]   pos;

  logic [psscan_pkg::LEN_W-1:0]   eff_len;
  logic [psscan_pkg::IDX_W-1:0]   last_idx;
  logic [psscan_pkg::IDX_W-1:0]   idx;
  logic                           is_last;
  logic                           cfg_we;

  assign cfg_ready     = 1'b1;
  assign cfg_we        = cfg_valid && cfg_ready;
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    priority if (line_length == '0) begin
      eff_len = psscan_pkg::LEN_W'(1);
    end else if (line_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = line_length;
    end
    last_idx = psscan_pkg::IDX_W'(eff_len - psscan_pkg::LEN_W'(1));
    idx      = (pos > last_idx) ? last_idx : pos;
    is_last  = (idx == last_idx);

    q_cmd.sample = s_axis_tdata;
    q_cmd.idx    = idx;
    q_cmd.last   = is_last;
    q_cmd.rev    = reverse_mode;
    q_cmd.excl   = exclusive_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exclusive_mode <= 1'b0;
      reverse_mode   <= 1'b0;
      line_length    <= psscan_pkg::LINE_LENGTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psscan_pkg::REG_EXCLUSIVE:   exclusive_mode <= cfg_data[0];
        psscan_pkg::REG_REVERSE:     reverse_mode   <= cfg_data[0];
        psscan_pkg::REG_LINE_LENGTH: line_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Any register write abandons a partial line.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pos <= '0;
    end else if (q_push) begin
      pos <= is_last ? '0 : idx + psscan_pkg::IDX_W'(1);
    end
  end

endmodule

// ----- src/psscan_queue.sv -----
// ----------------------------------------------------------------------------
// psscan_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module psscan_queue #(
  parameter int DEPTH = psscan_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  psscan_pkg::cmd_t push_cmd,
  input  logic             pop,
  output psscan_pkg::cmd_t head,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  psscan_pkg::cmd_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- src/psscan_back.sv -----
// ----------------------------------------------------------------------------
// psscan_back
// Executes commands: forward sums at once, reverse lines stored and then
// drained from the highest index down through the line store.
// ----------------------------------------------------------------------------
module psscan_back #(
  parameter int MAX_LINE = psscan_pkg::MAX_LINE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  psscan_pkg::cmd_t                    head,
  input  logic                                empty,
  output logic                                pop,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [psscan_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int PAD_W = psscan_pkg::OUT_TDATA_W - psscan_pkg::SUM_W - psscan_pkg::IDX_W;

  psscan_pkg::back_state_t state, state_next;

  logic [psscan_pkg::SUM_W-1:0]    acc;
  logic [psscan_pkg::SUM_W-1:0]    dsum;
  logic [psscan_pkg::IDX_W-1:0]    ptr;
  logic                            dexcl;

  logic                            ov;
  logic [psscan_pkg::SUM_W-1:0]    out_sum;
  logic [psscan_pkg::IDX_W-1:0]    out_idx;
  logic                            out_last;

  logic                            out_free;
  logic                            load;
  logic                            ram_we;
  logic                            ram_re;
  logic                            start_drain;
  logic [psscan_pkg::SAMPLE_W-1:0] ram_rdata;

  logic [psscan_pkg::SUM_W-1:0]    fwd_base;
  logic [psscan_pkg::SUM_W-1:0]    fwd_sum;
  logic [psscan_pkg::SUM_W-1:0]    drn_sum;
  logic [psscan_pkg::SUM_W-1:0]    load_sum;
  logic [psscan_pkg::IDX_W-1:0]    load_idx;
  logic                            load_last;

  assign out_free = !ov || m_axis_tready;

  // Index zero starts a new line, so the forward sum restarts there.
  assign fwd_base = (head.idx == '0) ? '0 : acc;
  assign fwd_sum  = fwd_base + psscan_pkg::sext_sample(head.sample);
  assign drn_sum  = dsum + psscan_pkg::sext_sample(ram_rdata);

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load        = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    start_drain = 1'b0;
    load_sum    = head.excl ? fwd_base : fwd_sum;
    load_idx    = head.idx;
    load_last   = head.last;
    unique case (state)
      psscan_pkg::B_IDLE: begin
        if (!empty && head.rev) begin
          pop    = 1'b1;
          ram_we = 1'b1;
          if (head.last) begin
            start_drain = 1'b1;
            state_next  = psscan_pkg::B_READ;
          end
        end else if (!empty && out_free) begin
          pop  = 1'b1;
          load = 1'b1;
        end
      end
      psscan_pkg::B_READ: begin
        ram_re     = 1'b1;
        state_next = psscan_pkg::B_EMIT;
      end
      psscan_pkg::B_EMIT: begin
        load_sum  = dexcl ? dsum : drn_sum;
        load_idx  = ptr;
        load_last = (ptr == '0);
        if (out_free) begin
          load       = 1'b1;
          state_next = (ptr == '0) ? psscan_pkg::B_IDLE : psscan_pkg::B_READ;
        end
      end
      default: state_next = psscan_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psscan_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (load && state == psscan_pkg::B_IDLE) begin
      acc <= fwd_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (start_drain) begin
      ptr   <= head.idx;
      dsum  <= '0;
      dexcl <= head.excl;
    end else if (load && state == psscan_pkg::B_EMIT) begin
      ptr  <= ptr - psscan_pkg::IDX_W'(1);
      dsum <= drn_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (load) begin
      ov <= 1'b1;
    end else if (m_axis_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sum  <= load_sum;
      out_idx  <= load_idx;
      out_last <= load_last;
    end
  end

  psscan_ram #(
    .WIDTH (psscan_pkg::SAMPLE_W),
    .DEPTH (MAX_LINE)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.idx[AW-1:0]),
    .wdata (head.sample),
    .re    (ram_re),
    .raddr (ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_idx, out_sum};
  assign m_axis_tlast  = out_last;

`ifndef SYNTH
  a_no_pop_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state != psscan_pkg::B_IDLE) |-> !pop)
    else $error("command taken while a line is draining");

  a_emit_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == psscan_pkg::B_READ) |=> (state == psscan_pkg::B_EMIT))
    else $error("read of the line store not followed by an emit");

  a_drain_ends_at_zero: assert property (@(posedge clk) disable iff (rst)
    (state == psscan_pkg::B_EMIT && load && ptr == '0) |=>
      (state == psscan_pkg::B_IDLE && m_axis_tlast))
    else $error("drain did not finish with the index zero result");

  a_store_only_reverse: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (head.rev && !empty))
    else $error("line store written by a forward command");
`endif

endmodule

// ----- dv/prefix_sum_scan_checker.sv -----
// ----------------------------------------------------------------------------
// prefix_sum_scan_checker
// Watches the sample, result and register channels of the prefix sum scan
// core, keeps its own copy of the scan state, predicts every result word and
// compares each one with the word that leaves the core.
// ----------------------------------------------------------------------------
module prefix_sum_scan_checker #(
  parameter int MAX_LINE = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [psscan_pkg::SAMPLE_W-1:0]     s_axis_tdata,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [psscan_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                                m_axis_tlast,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [psscan_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psscan_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                  pending,
  output int                                  fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [psscan_pkg::SUM_W-1:0] total;
    logic [psscan_pkg::IDX_W-1:0] idx;
    logic                         done;
  } line_sum_t;

  line_sum_t                       line_sums_due[$];
  logic                            excl_mode;
  logic                            rev_mode;
  logic [psscan_pkg::LEN_W-1:0]    line_len;
  logic [psscan_pkg::SUM_W-1:0]    acc;
  logic [psscan_pkg::LEN_W-1:0]    pos;
  logic [psscan_pkg::SAMPLE_W-1:0] held [MAX_LINE];
  int                              errors = 0;

  function automatic logic [psscan_pkg::LEN_W-1:0] active_length();
    if (line_len == '0) return psscan_pkg::LEN_W'(1);
    if (line_len > MAX_LINE) return psscan_pkg::LEN_W'(MAX_LINE);
    return line_len;
  endfunction

  task automatic clear_scan_state();
    excl_mode = 1'b0;
    rev_mode  = 1'b0;
    line_len  = psscan_pkg::LINE_LENGTH_RESET;
    acc       = '0;
    pos       = '0;
    foreach (held[i]) held[i] = '0;
    line_sums_due.delete();
  endtask

  task automatic apply_write();
    case (cfg_index)
      psscan_pkg::REG_EXCLUSIVE:   excl_mode = cfg_data[0];
      psscan_pkg::REG_REVERSE:     rev_mode  = cfg_data[0];
      psscan_pkg::REG_LINE_LENGTH: line_len  = cfg_data;
      default: ;
    endcase
    // Any write, even to an unused index, abandons the line in progress.
    acc = '0;
    pos = '0;
  endtask

  task automatic scan_sample(input logic [psscan_pkg::SAMPLE_W-1:0] x);
    logic [psscan_pkg::LEN_W-1:0]    len;
    logic [psscan_pkg::LEN_W-1:0]    idx;
    logic                            is_last;
    logic [psscan_pkg::SUM_W-1:0]    total;
    logic [psscan_pkg::SAMPLE_W-1:0] v;
    line_sum_t                       r;
    int                              i;
    len     = active_length();
    idx     = (pos >= len) ? len - 1'b1 : pos;
    is_last = (idx == len - 1'b1);
    if (!rev_mode) begin
      if (excl_mode) begin
        r.total = acc;
        acc     = acc + psscan_pkg::sext_sample(x);
      end else begin
        acc     = acc + psscan_pkg::sext_sample(x);
        r.total = acc;
      end
      r.idx  = idx[psscan_pkg::IDX_W-1:0];
      r.done = is_last;
      line_sums_due.push_back(r);
      if (is_last) begin
        pos = '0;
        acc = '0;
      end else begin
        pos = idx + 1'b1;
      end
    end else begin
      held[idx] = x;
      if (!is_last) begin
        pos = idx + 1'b1;
      end else begin
        // The whole line is in; sums run from the top index down to zero.
        total = '0;
        for (i = int'(len) - 1; i >= 0; i--) begin
          v      = held[i];
          r.idx  = psscan_pkg::IDX_W'(i);
          r.done = (i == 0);
          if (excl_mode) begin
            r.total = total;
            total   = total + psscan_pkg::sext_sample(v);
          end else begin
            total   = total + psscan_pkg::sext_sample(v);
            r.total = total;
          end
          line_sums_due.push_back(r);
        end
        pos = '0;
        acc = '0;
      end
    end
  endtask

  task automatic check_word();
    line_sum_t                    want;
    logic [psscan_pkg::SUM_W-1:0] got_total;
    logic [psscan_pkg::IDX_W-1:0] got_idx;
    got_total = m_axis_tdata[psscan_pkg::SUM_W-1:0];
    got_idx   = m_axis_tdata[psscan_pkg::SUM_W +: psscan_pkg::IDX_W];
    if (line_sums_due.size() == 0) begin
      $display("%0t: unexpected word, sum %h index %0d last %b", $time,
               got_total, got_idx, m_axis_tlast);
      errors++;
    end else begin
      want = line_sums_due.pop_front();
      if (got_total !== want.total) begin
        $display("%0t: running_sum expected %h, got %h", $time, want.total, got_total);
        errors++;
      end
      if (got_idx !== want.idx) begin
        $display("%0t: element_index expected %0d, got %0d", $time, want.idx, got_idx);
        errors++;
      end
      if (m_axis_tlast !== want.done) begin
        $display("%0t: line_done expected %b, got %b", $time, want.done, m_axis_tlast);
        errors++;
      end
    end
  endtask

  // A result word always stems from an earlier sample, so it is checked
  // before the sample taken at the same edge adds its own sums.
  always @(posedge clk) begin
    if (rst) begin
      clear_scan_state();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (cfg_valid && cfg_ready) apply_write();
      if (s_axis_tvalid && s_axis_tready) scan_sample(s_axis_tdata);
    end
    pending    <= line_sums_due.size();
    fail_count <= errors;
  end

endmodule

// ----- dv/prefix_sum_scan_core_test.sv -----
// ----------------------------------------------------------------------------
// prefix_sum_scan_core_test
// Drives the prefix sum scan core with directed lines and random phases over
// all mode settings and many line lengths, under bursty input and a stalling
// output, while the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module prefix_sum_scan_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [psscan_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int RESET_CYCLES = 7;
  localparam int QUIET_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 80;
  localparam int LIMIT_CYCLES = 400000;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [psscan_pkg::SAMPLE_W-1:0]      s_axis_tdata = '0;
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [psscan_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                                 m_axis_tlast;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [psscan_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [psscan_pkg::CFG_DATA_W-1:0]    cfg_data = '0;

  int pending;
  int fail_count;
  int cycle_count = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int burst_left = 0;
  int gap_max = 3;
  int sent_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  prefix_sum_scan_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  prefix_sum_scan_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pending       (pending),
    .fail_count    (fail_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: stretches of always-ready, coin-flip and mostly-stalled
  // acceptance, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(10, 60);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic logic [psscan_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return {{16{1'($urandom_range(0, 1))}}, 16'($urandom_range(0, 65535))};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [psscan_pkg::CFG_DATA_W-1:0] pick_length();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return psscan_pkg::CFG_DATA_W'($urandom_range(65, 127));
      2:       return psscan_pkg::CFG_DATA_W'(64);
      3:       return psscan_pkg::CFG_DATA_W'($urandom_range(9, 40));
      default: return psscan_pkg::CFG_DATA_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic write_reg(input logic [psscan_pkg::CFG_IDX_W-1:0] index,
                           input logic [psscan_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Samples go out in bursts of random length with random gaps between.
  task automatic send_sample(input logic [psscan_pkg::SAMPLE_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
  endtask

  // Waits for every outstanding word, then lets a partial reverse line that
  // produced nothing work its way through before registers change.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase();
    logic [psscan_pkg::CFG_DATA_W-1:0] len;
    int eff;
    if ($urandom_range(0, 4) == 0) begin
      write_reg(REG_NONE, psscan_pkg::CFG_DATA_W'($urandom_range(0, 127)));
    end
    write_reg(psscan_pkg::REG_EXCLUSIVE, psscan_pkg::CFG_DATA_W'($urandom_range(0, 127)));
    write_reg(psscan_pkg::REG_REVERSE, psscan_pkg::CFG_DATA_W'($urandom_range(0, 127)));
    len = pick_length();
    write_reg(psscan_pkg::REG_LINE_LENGTH, len);
    eff = (len == 0) ? 1 : (len > 64) ? 64 : int'(len);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (eff > 12) begin
      // Long lines only get a partial run; the next write drops it.
      repeat ($urandom_range(1, 8)) send_sample(pick_sample());
    end else begin
      repeat ($urandom_range(1, 3) * eff) send_sample(pick_sample());
      if (eff > 1 && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, eff - 1)) send_sample(pick_sample());
      end
    end
    settle();
  endtask

  initial begin
    int k;
    int base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: forward, inclusive, 64-element lines.
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    settle();
    write_reg(REG_NONE, 7'h55);
    write_reg(psscan_pkg::REG_LINE_LENGTH, 7'd4);
    repeat (4) send_sample(32'h8000_0000);
    settle();
    write_reg(psscan_pkg::REG_EXCLUSIVE, 7'h7F);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0001_0000);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    settle();
    write_reg(psscan_pkg::REG_REVERSE, 7'd1);
    write_reg(psscan_pkg::REG_LINE_LENGTH, 7'd3);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'hFFFF_0000);
    send_sample(32'h8000_0000);
    settle();
    // A reverse line cut short by a register write yields nothing.
    write_reg(psscan_pkg::REG_EXCLUSIVE, 7'h00);
    send_sample(32'h1234_5678);
    send_sample(32'hEDCB_A987);
    settle();
    write_reg(psscan_pkg::REG_LINE_LENGTH, 7'd2);
    send_sample(32'h0000_0001);
    send_sample(32'hFFFF_FFFF);
    settle();
    write_reg(psscan_pkg::REG_LINE_LENGTH, 7'd0);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    settle();
    write_reg(psscan_pkg::REG_REVERSE, 7'h7E);
    send_sample(32'hAAAA_5555);
    settle();
    write_reg(psscan_pkg::REG_LINE_LENGTH, 7'd127);
    send_sample(32'h5555_AAAA);
    send_sample(32'hFFFF_FFFF);
    settle();

    // A full clamped reverse line; the output holds off near its end so the
    // drain backs up while the next line keeps being offered.
    base = sent_count;
    write_reg(psscan_pkg::REG_REVERSE, 7'd1);
    write_reg(psscan_pkg::REG_EXCLUSIVE, psscan_pkg::CFG_DATA_W'($urandom_range(0, 127)));
    write_reg(psscan_pkg::REG_LINE_LENGTH, 7'd127);
    gap_max = 0;
    for (k = 0; k < 74; k++) begin
      if (k == 56) hold_req <= hold_req + 1;
      send_sample(pick_sample());
    end
    settle();

    while (sent_count < base + RANDOM_ITEMS) run_random_phase();

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- prefix_sum_scan_core.f -----
src/psscan_pkg.sv
src/psscan_ram.sv
src/psscan_front.sv
src/psscan_queue.sv
src/psscan_back.sv
src/prefix_sum_scan_core.sv
dv/prefix_sum_scan_checker.sv
dv/prefix_sum_scan_core_test.sv
